// File: sv/ksup_pkg.sv
// ----------------------------------------------------------------------------
// ksup_pkg
// Shared sizes, codes and types of the keyed stack with unique push keys.
// ----------------------------------------------------------------------------
package ksup_pkg;

   localparam int DEPTH         = 16;
   localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W         = $clog2(DEPTH + 1);
   localparam int KEY_W         = 32;
   localparam int DATA_W        = 32;
   localparam int OP_W          = 2;
   localparam int STATUS_W      = 2;
   localparam int COUNT_FIELD_W = 5;
   localparam int REQ_TDATA_W   = 64;
   localparam int RSP_TDATA_W   = 72;

   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic                     wr_en;
      logic [ADDR_W-1:0]        wr_addr;
      logic signed [KEY_W-1:0]  wr_key;
      logic signed [DATA_W-1:0] wr_data;
      logic                     rd_en;
      logic [ADDR_W-1:0]        rd_addr;
   } store_req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]  key;
      logic signed [DATA_W-1:0] data;
   } store_rsp_type;

   // entry count as reported on the result word, masked to the field width
   function automatic logic [COUNT_FIELD_W-1:0] count_to_field(input logic [CNT_W-1:0] c);
      return COUNT_FIELD_W'(c);
   endfunction

endpackage

// File: sv/ksup_store.sv
// ----------------------------------------------------------------------------
// ksup_store
// Key and data entry memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ksup_store (
   input  logic                   clock,
   input  ksup_pkg::store_req_type store_req,
   output ksup_pkg::store_rsp_type store_rsp
);
   import ksup_pkg::*;

   logic signed [KEY_W-1:0]  key_mem  [DEPTH];
   logic signed [DATA_W-1:0] data_mem [DEPTH];
   logic signed [KEY_W-1:0]  rd_key_ff;
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         key_mem[store_req.wr_addr]  <= store_req.wr_key;
         data_mem[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_key_ff  <= key_mem[store_req.rd_addr];
         rd_data_ff <= data_mem[store_req.rd_addr];
      end
   end

   assign store_rsp.key  = rd_key_ff;
   assign store_rsp.data = rd_data_ff;

endmodule

// File: sv/ksup_ctrl.sv
// ----------------------------------------------------------------------------
// ksup_ctrl
// Sequencer: stack pointer, key scan with one shared comparator, result word.
// ----------------------------------------------------------------------------
module ksup_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ksup_pkg::OP_W-1:0]            req_op,
   input  logic signed [ksup_pkg::KEY_W-1:0]    req_key,
   input  logic signed [ksup_pkg::DATA_W-1:0]   req_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic signed [ksup_pkg::KEY_W-1:0]    rsp_key,
   output logic signed [ksup_pkg::DATA_W-1:0]   rsp_data,
   output logic [ksup_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_empty,
   output logic [ksup_pkg::COUNT_FIELD_W-1:0]   rsp_count,
   output ksup_pkg::store_req_type              store_req,
   input  ksup_pkg::store_rsp_type              store_rsp
);
   import ksup_pkg::*;

   state_type state_ff, state_in;

   logic [OP_W-1:0]          op_ff, op_in;
   logic signed [KEY_W-1:0]  key_ff, key_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic                     cmp_valid_ff, cmp_valid_in;
   logic                     cmp_last_ff, cmp_last_in;
   logic signed [KEY_W-1:0]  res_key_ff, res_key_in;
   logic signed [DATA_W-1:0] res_data_ff, res_data_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic [COUNT_FIELD_W-1:0] rsp_count_ff, rsp_count_in;

   logic                     scan_match;
   logic                     scan_commit;
   logic                     slot_free;
   logic                     stack_full;
   logic                     stack_empty;
   logic [CNT_W-1:0]         top_idx;

   assign stack_full  = (count_ff >= CNT_W'(DEPTH));
   assign stack_empty = (count_ff == '0);
   assign top_idx     = count_ff - CNT_W'(1);
   assign slot_free   = !rsp_valid_ff || rsp_tready;

   // compare the word read last cycle; commit once every stored key was seen
   assign scan_match  = cmp_valid_ff && (store_rsp.key == key_ff);
   assign scan_commit = !scan_match &&
                        ((!cmp_valid_ff && stack_empty) || (cmp_valid_ff && cmp_last_ff));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_op)
                  OP_PUSH: state_in = stack_full ? ST_RESULT : ST_SCAN;
                  OP_POP,
                  OP_PEEK: state_in = stack_empty ? ST_RESULT : ST_READ;
                  default: state_in = ST_RESULT;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_match || scan_commit) begin
               state_in = ST_RESULT;
            end
         end
         ST_READ: state_in = ST_RESULT;
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = (state_ff == ST_IDLE);

      store_req.wr_en   = 1'b0;
      store_req.wr_addr = count_ff[ADDR_W-1:0];
      store_req.wr_key  = key_ff;
      store_req.wr_data = data_ff;
      store_req.rd_en   = 1'b0;
      store_req.rd_addr = idx_ff[ADDR_W-1:0];

      op_in         = op_ff;
      key_in        = key_ff;
      data_in       = data_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_last_in   = cmp_last_ff;
      res_key_in    = res_key_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_key_in    = rsp_key_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            cmp_valid_in = 1'b0;
            cmp_last_in  = 1'b0;
            idx_in       = '0;
            if (req_tvalid) begin
               op_in         = req_op;
               key_in        = req_key;
               data_in       = req_data;
               res_key_in    = '0;
               res_data_in   = '0;
               res_status_in = STATUS_OK;
               case (req_op)
                  OP_PUSH: begin
                     if (stack_full) begin
                        res_status_in = STATUS_OVER;
                     end
                  end
                  OP_POP,
                  OP_PEEK: begin
                     if (stack_empty) begin
                        res_status_in = STATUS_UNDER;
                     end else begin
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = top_idx[ADDR_W-1:0];
                     end
                  end
                  default: res_status_in = STATUS_OK;
               endcase
            end
         end
         ST_SCAN: begin
            // issue one stored key per cycle, bottom first
            if (idx_ff != count_ff) begin
               store_req.rd_en = 1'b1;
               idx_in          = idx_ff + CNT_W'(1);
               cmp_valid_in    = 1'b1;
               cmp_last_in     = (idx_ff == top_idx);
            end else begin
               cmp_valid_in    = 1'b0;
            end
            if (scan_match) begin
               res_status_in = STATUS_DUP;
            end else if (scan_commit) begin
               store_req.wr_en = 1'b1;
               count_in        = count_ff + CNT_W'(1);
            end
         end
         ST_READ: begin
            res_key_in  = store_rsp.key;
            res_data_in = store_rsp.data;
            if (op_ff == OP_POP) begin
               count_in = top_idx;
            end
         end
         ST_RESULT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_key_in    = res_key_ff;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               rsp_empty_in  = stack_empty;
               rsp_count_in  = count_to_field(count_ff);
            end
         end
         default: begin
            cmp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      data_ff       <= data_in;
      idx_ff        <= idx_in;
      cmp_last_ff   <= cmp_last_in;
      res_key_ff    <= res_key_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_key    = rsp_key_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_empty  = rsp_empty_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// File: sv/keyed_stack_unique_push_unit.sv
// ----------------------------------------------------------------------------
// keyed_stack_unique_push_unit
// Bounded LIFO of key/data entries; a push whose key is already stored is
// refused.
//
// The request stream carries the operation in req_tuser (push, pop, peek) and
// the key and data in req_tdata. Each request yields one response word with
// the popped or peeked entry, a status code, an empty flag and the entry count.
// A request is taken only while the unit is idle, so a new request waits until
// the last one has placed its response in the output register. Pop and peek
// read the top entry and then present the response. A push first runs the
// duplicate check, which reads one stored key per cycle through the single
// memory read port and one comparator; a key found early ends the scan there.
// A refused push on a full stack or an undefined operation skips the memory
// and goes straight to the response.
// The response sits in an output register; a stalled receiver holds it there
// and the unit keeps the next result until the register is free. Reset empties
// the stack and drops any pending response; the entry memory is not cleared.
// ----------------------------------------------------------------------------
module keyed_stack_unique_push_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [31:0] in_key, [63:32] in_data
   input  logic [ksup_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // [1:0] op
   input  logic [ksup_pkg::OP_W-1:0]             req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] out_key, [63:32] out_data, [64] is_empty, [69:65] entry_count,
   // [71:70] zero
   output logic [ksup_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // [1:0] status
   output logic [ksup_pkg::STATUS_W-1:0]         rsp_tuser
);
   import ksup_pkg::*;

   store_req_type            store_req;
   store_rsp_type            store_rsp;
   logic signed [KEY_W-1:0]  rsp_key;
   logic signed [DATA_W-1:0] rsp_data;
   logic                     rsp_empty;
   logic [COUNT_FIELD_W-1:0] rsp_count;

   ksup_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_key    (req_tdata[KEY_W-1:0]),
      .req_data   (req_tdata[KEY_W+DATA_W-1:KEY_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_key    (rsp_key),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_tuser),
      .rsp_empty  (rsp_empty),
      .rsp_count  (rsp_count),
      .store_req  (store_req),
      .store_rsp  (store_rsp)
   );

   ksup_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .store_rsp (store_rsp)
   );

   // pack the response word, pad to whole bytes
   assign rsp_tdata = {{(RSP_TDATA_W - KEY_W - DATA_W - 1 - COUNT_FIELD_W){1'b0}},
                       rsp_count, rsp_empty, rsp_data, rsp_key};

endmodule
